// File: rtl/rmq_pkg.sv
package rmq_pkg;

  // Sequencer states of the range minimum unit.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLD_LVL,
    ST_BLD_RA,
    ST_BLD_RB,
    ST_BLD_WR,
    ST_Q_RA,
    ST_Q_RB,
    ST_Q_RES
  } rmq_state_t;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned QIDX_W  = 10;
  localparam int unsigned QLEN_W  = QIDX_W + 1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Signed minimum of two words.
  function automatic logic signed [DATA_W-1:0] smin(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    return (a <= b) ? a : b;
  endfunction

endpackage

// File: rtl/rmq_ram.sv
module rmq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/rmq_lvl.sv
module rmq_lvl #(
  parameter int unsigned LEVELS = 11
) (
  input  logic [rmq_pkg::QLEN_W-1:0] len,
  output logic [$clog2(LEVELS)-1:0]  lvl
);

  // Floor of log2 of the range length, capped at the top table level.
  always_comb begin
    lvl = '0;
    for (int k = 1; k < int'(LEVELS); k++) begin
      if ((len >> k) != '0) begin
        lvl = ($clog2(LEVELS))'(k);
      end
    end
  end

endmodule

// File: rtl/range_minimum_sparse_table_unit.sv
// Range minimum unit over a sparse table held in one RAM with one read port.
// Load transaction: no result. A last load starts a build that, level by level,
// does two reads and a write per table entry. Query transaction: reads two
// entries, registers their minimum; no new transaction is taken until a build
// or query ends. Reset clears the count, the table-built flag, the sequencer
// and the result valid flag; the table RAM and the result fields are not cleared.
module range_minimum_sparse_table_unit #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned LEVELS       = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic signed [rmq_pkg::DATA_W-1:0]   value,
  input  logic                                last,
  input  logic [rmq_pkg::QIDX_W-1:0]          range_start,
  input  logic [rmq_pkg::QIDX_W-1:0]          range_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rmq_pkg::DATA_W-1:0]   min_value,
  output logic                                error
);

  // Widths that follow from the table shape. Level k occupies the words
  // k * MAX_ELEMENTS up to k * MAX_ELEMENTS + MAX_ELEMENTS - 1.
  localparam int unsigned DEPTH  = MAX_ELEMENTS * LEVELS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int unsigned KW     = $clog2(LEVELS + 1);
  localparam int unsigned LVL_W  = $clog2(LEVELS);
  localparam int unsigned SPW    = CNT_W + 1;
  localparam int unsigned QW     = (CNT_W > rmq_pkg::QLEN_W) ? CNT_W : rmq_pkg::QLEN_W;

  rmq_pkg::rmq_state_t state, state_next;

  // Control state.
  logic [CNT_W-1:0]  count;
  logic              table_ready;
  // Build walk: current level, entry, and the bases of the source and
  // destination levels.
  logic [KW-1:0]     lvl_k;
  logic [IDX_W-1:0]  ent;
  logic [ADDR_W-1:0] src_base;
  logic [ADDR_W-1:0] dst_base;
  // First operand held while the second read is under way.
  logic [rmq_pkg::DATA_W-1:0] opa;
  // Query registers.
  logic [ADDR_W-1:0] q_addr_a;
  logic [ADDR_W-1:0] q_addr_b;
  logic              q_err;

  // RAM port signals.
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_wr_addr;
  logic [rmq_pkg::DATA_W-1:0] ram_wr_data;
  logic [ADDR_W-1:0]          ram_rd_addr;
  logic [rmq_pkg::DATA_W-1:0] ram_rd_data;

  rmq_ram #(
    .WIDTH (rmq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Query decode: validity, range length, level and the two table addresses.
  logic [QW-1:0]              q_start_w;
  logic [QW-1:0]              q_end_w;
  logic                       q_bad;
  logic [rmq_pkg::QLEN_W-1:0] q_len;
  logic [LVL_W-1:0]           q_lvl;
  logic [rmq_pkg::QLEN_W-1:0] q_second;
  logic [ADDR_W-1:0]          q_lvl_base;

  assign q_start_w = QW'(range_start);
  assign q_end_w   = QW'(range_end);
  assign q_bad     = !table_ready || (q_start_w > q_end_w) || (q_end_w >= QW'(count));
  assign q_len     = rmq_pkg::QLEN_W'(range_end) - rmq_pkg::QLEN_W'(range_start)
                   + rmq_pkg::QLEN_W'(1);

  rmq_lvl #(
    .LEVELS (LEVELS)
  ) u_lvl (
    .len (q_len),
    .lvl (q_lvl)
  );

  assign q_second   = rmq_pkg::QLEN_W'(range_end) + rmq_pkg::QLEN_W'(1)
                    - (rmq_pkg::QLEN_W'(1) << q_lvl);
  assign q_lvl_base = ADDR_W'(q_lvl) * ADDR_W'(MAX_ELEMENTS);

  // A load after a completed build starts a fresh array at index zero.
  logic [CNT_W-1:0] load_idx;
  logic             load_room;
  assign load_idx  = table_ready ? '0 : count;
  assign load_room = (load_idx < CNT_W'(MAX_ELEMENTS));

  // Build helpers: a level exists while its span fits in the count, and the
  // walk over a level ends at entry count - span.
  logic              lvl_fits;
  logic              ent_final;
  logic [ADDR_W-1:0] half;
  assign lvl_fits  = (lvl_k < KW'(LEVELS)) && ((count >> lvl_k) != '0);
  assign ent_final = (SPW'(ent) + (SPW'(1) << lvl_k)) >= SPW'(count);
  assign half      = ADDR_W'(1) << (lvl_k - KW'(1));

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    ram_wr_addr = dst_base + ADDR_W'(ent);
    ram_wr_data = rmq_pkg::smin(opa, ram_rd_data);
    ram_rd_addr = src_base + ADDR_W'(ent);
    unique case (state)
      rmq_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ram_wr_addr = ADDR_W'(load_idx);
        ram_wr_data = value;
        if (in_valid) begin
          if (kind == rmq_pkg::KIND_LOAD) begin
            ram_we = load_room;
            if (last) begin
              state_next = rmq_pkg::ST_BLD_LVL;
            end
          end else begin
            state_next = rmq_pkg::ST_Q_RA;
          end
        end
      end
      rmq_pkg::ST_BLD_LVL: begin
        state_next = lvl_fits ? rmq_pkg::ST_BLD_RA : rmq_pkg::ST_IDLE;
      end
      rmq_pkg::ST_BLD_RA: begin
        state_next = rmq_pkg::ST_BLD_RB;
      end
      rmq_pkg::ST_BLD_RB: begin
        ram_rd_addr = src_base + ADDR_W'(ent) + half;
        state_next  = rmq_pkg::ST_BLD_WR;
      end
      rmq_pkg::ST_BLD_WR: begin
        ram_we     = 1'b1;
        state_next = ent_final ? rmq_pkg::ST_BLD_LVL : rmq_pkg::ST_BLD_RA;
      end
      rmq_pkg::ST_Q_RA: begin
        ram_rd_addr = q_addr_a;
        state_next  = rmq_pkg::ST_Q_RB;
      end
      rmq_pkg::ST_Q_RB: begin
        ram_rd_addr = q_addr_b;
        state_next  = rmq_pkg::ST_Q_RES;
      end
      rmq_pkg::ST_Q_RES: begin
        // Keep the second address on the port so its data holds while the
        // result register is still occupied.
        ram_rd_addr = q_addr_b;
        if (out_free) begin
          state_next = rmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rmq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      table_ready <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == rmq_pkg::ST_IDLE && in_valid && kind == rmq_pkg::KIND_LOAD) begin
        table_ready <= 1'b0;
        count       <= load_room ? (load_idx + CNT_W'(1)) : load_idx;
      end
      if (state == rmq_pkg::ST_BLD_LVL && !lvl_fits) begin
        table_ready <= 1'b1;
      end
      if (state == rmq_pkg::ST_Q_RES && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      rmq_pkg::ST_IDLE: begin
        lvl_k    <= KW'(1);
        ent      <= '0;
        src_base <= '0;
        dst_base <= ADDR_W'(MAX_ELEMENTS);
        q_err    <= q_bad;
        // A bad query never reads a meaningful entry; park it at address zero.
        q_addr_a <= q_bad ? '0 : (q_lvl_base + ADDR_W'(IDX_W'(range_start)));
        q_addr_b <= q_bad ? '0 : (q_lvl_base + ADDR_W'(IDX_W'(q_second)));
      end
      rmq_pkg::ST_BLD_RB, rmq_pkg::ST_Q_RB: begin
        opa <= ram_rd_data;
      end
      rmq_pkg::ST_BLD_WR: begin
        if (ent_final) begin
          lvl_k    <= lvl_k + KW'(1);
          ent      <= '0;
          src_base <= dst_base;
          dst_base <= dst_base + ADDR_W'(MAX_ELEMENTS);
        end else begin
          ent <= ent + IDX_W'(1);
        end
      end
      rmq_pkg::ST_Q_RES: begin
        if (out_free) begin
          min_value <= q_err ? '0 : rmq_pkg::smin(opa, ram_rd_data);
          error     <= q_err;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
